@@ rtl/core/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MIN = 3'd4,
        OP_MAX = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [DATA_W-1:0]        res;
        logic                     less;
        logic                     equal;
        logic                     greater;
        logic                     dz;
    } item_t;

endpackage

@@ rtl/core/fpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// Accept items, decode the op, compute compare flags and the simple ops.
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fpa_pkg::S_TDATA_W-1:0]    s_tdata,   // op, operand_a, operand_b
    output logic                             push_valid,
    input  logic                             push_ready,
    output fpa_pkg::item_t                   push_item
);

    logic                             valid_reg;
    logic                             valid_next;
    fpa_pkg::item_t                   item_reg;
    fpa_pkg::item_t                   item_next;
    logic [fpa_pkg::OP_W-1:0]         op_raw;
    logic signed [fpa_pkg::DATA_W-1:0] a;
    logic signed [fpa_pkg::DATA_W-1:0] b;
    logic                             accept;

    assign op_raw = s_tdata[2:0];
    assign a      = s_tdata[34:3];
    assign b      = s_tdata[66:35];

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next         = item_reg;
        item_next.a       = a;
        item_next.b       = b;
        item_next.less    = a < b;
        item_next.equal   = a == b;
        item_next.greater = a > b;
        item_next.dz      = 1'b0;
        item_next.kind    = fpa_pkg::KIND_SIMPLE;
        item_next.res     = '0;
        case (op_raw)
            fpa_pkg::OP_ADD: item_next.res = a + b;
            fpa_pkg::OP_SUB: item_next.res = a - b;
            fpa_pkg::OP_MUL: item_next.kind = fpa_pkg::KIND_MUL;
            fpa_pkg::OP_DIV: begin
                item_next.kind = fpa_pkg::KIND_DIV;
                item_next.dz   = (b == '0);
            end
            fpa_pkg::OP_MIN: item_next.res = (a < b) ? a : b;
            fpa_pkg::OP_MAX: item_next.res = (a > b) ? a : b;
            default:         item_next.res = '0;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/fpa_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_fifo
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module fpa_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  fpa_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output fpa_pkg::item_t pop_item
);

    fpa_pkg::item_t                  mem_reg [fpa_pkg::QUEUE_DEPTH];
    logic [fpa_pkg::QUEUE_AW-1:0]    wptr_reg;
    logic [fpa_pkg::QUEUE_AW-1:0]    wptr_next;
    logic [fpa_pkg::QUEUE_AW-1:0]    rptr_reg;
    logic [fpa_pkg::QUEUE_AW-1:0]    rptr_next;
    logic [fpa_pkg::QUEUE_AW:0]      count_reg;
    logic [fpa_pkg::QUEUE_AW:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = count_reg != (fpa_pkg::QUEUE_AW + 1)'(fpa_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (do_push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/fpa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// Execute pipeline: registered multiply, one-bit-per-stage divider, output.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop,
    input  fpa_pkg::item_t                pop_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fpa_pkg::M_TDATA_W-1:0] m_tdata   // result, less, equal, greater,
                                                    // div_by_zero
);

    localparam int DW = fpa_pkg::DATA_W + FRAC_BITS;
    localparam int W  = fpa_pkg::DATA_W;

    typedef struct packed {
        fpa_pkg::kind_t kind;
        logic [W-1:0]   res;
        logic           less;
        logic           equal;
        logic           greater;
        logic           dz;
        logic           neg;
        logic [DW-1:0]  dvd;
        logic [W-1:0]   rem;
        logic [W-1:0]   dsr;
    } stage_t;

    stage_t                  stg_reg  [DW+1];
    stage_t                  stg_next [DW+1];
    logic                    vld_reg  [DW+1];
    logic signed [2*W-1:0]   prod_reg;
    logic signed [2*W-1:0]   prod_next;
    logic                    out_valid_reg;
    logic [fpa_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [fpa_pkg::M_TDATA_W-1:0] out_data_next;
    logic                    advance;
    logic [W-1:0]            mag_a;
    logic [W-1:0]            mag_b;
    logic [DW-1:0]           quo;
    logic [W-1:0]            res_fin;
    logic signed [2*W-1:0]   prod_sh;

    assign advance  = !out_valid_reg || m_tready;
    assign pop      = advance && pop_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign mag_a     = pop_item.a[W-1] ? W'(-pop_item.a) : W'(pop_item.a);
    assign mag_b     = pop_item.b[W-1] ? W'(-pop_item.b) : W'(pop_item.b);
    assign prod_next = (2*W)'(pop_item.a) * (2*W)'(pop_item.b);
    assign prod_sh   = prod_reg >>> FRAC_BITS;

    always_comb begin
        logic [W:0] r;
        stg_next[0].kind    = pop_item.kind;
        stg_next[0].res     = pop_item.res;
        stg_next[0].less    = pop_item.less;
        stg_next[0].equal   = pop_item.equal;
        stg_next[0].greater = pop_item.greater;
        stg_next[0].dz      = pop_item.dz;
        stg_next[0].neg     = pop_item.a[W-1] ^ pop_item.b[W-1];
        stg_next[0].dvd     = DW'(mag_a) << FRAC_BITS;
        stg_next[0].rem     = '0;
        stg_next[0].dsr     = mag_b;
        for (int k = 1; k <= DW; k++) begin
            stg_next[k] = stg_reg[k-1];
            if (k == 1 && stg_reg[0].kind == fpa_pkg::KIND_MUL) begin
                stg_next[k].res = prod_sh[W-1:0];
            end
            r = {stg_reg[k-1].rem, stg_reg[k-1].dvd[DW-1]};
            if (r >= {1'b0, stg_reg[k-1].dsr}) begin
                stg_next[k].rem = W'(r - {1'b0, stg_reg[k-1].dsr});
                stg_next[k].dvd = {stg_reg[k-1].dvd[DW-2:0], 1'b1};
            end else begin
                stg_next[k].rem = r[W-1:0];
                stg_next[k].dvd = {stg_reg[k-1].dvd[DW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        quo     = stg_reg[DW].neg ? DW'(-stg_reg[DW].dvd) : stg_reg[DW].dvd;
        res_fin = stg_reg[DW].res;
        if (stg_reg[DW].kind == fpa_pkg::KIND_DIV) begin
            res_fin = stg_reg[DW].dz ? '0 : quo[W-1:0];
        end
        out_data_next = {4'b0000, stg_reg[DW].dz, stg_reg[DW].greater,
                         stg_reg[DW].equal, stg_reg[DW].less, res_fin};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= DW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            out_valid_reg <= vld_reg[DW];
            vld_reg[0]    <= pop_valid;
            for (int k = 1; k <= DW; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            prod_reg     <= prod_next;
            for (int k = 0; k <= DW; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

endmodule

@@ rtl/core/fixed_point_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU: add, sub, mul, div, min, max with flags.
// Path: the front register, the item queue, the divider's one-bit-per-stage
// pipeline, then the output register; a four-entry queue decouples front and back.
// Throughput: one item per cycle unless m_tready stalls the output.
// Reset: synchronous, active low; clears all valid and queue state.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fpa_pkg::S_TDATA_W-1:0] s_tdata,   // op, operand_a, operand_b
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fpa_pkg::M_TDATA_W-1:0] m_tdata    // result, less, equal, greater,
                                                     // div_by_zero
);

    logic           push_valid;
    logic           push_ready;
    fpa_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop;
    fpa_pkg::item_t pop_item;

    fpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fpa_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
